[rtl/block_bitmap_allocator_unit_defines.svh]
// Assertion helpers shared by the allocator RTL. They assume a clock named clk and
// an active-low asynchronous reset named arst_n in the module that uses them.
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bba_pkg.sv]
`default_nettype none

package bba_pkg;

	localparam int WORD_W       = 64;
	localparam int BIT_SEL_W    = 6;
	localparam int INDEX_W      = 12;
	localparam int INDEX_SPAN   = 4096;
	localparam int MAX_WORDS    = INDEX_SPAN / WORD_W;
	localparam int TOTAL_W      = 13;
	localparam int COUNT_W      = 13;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;

	localparam logic [TOTAL_W-1:0]    TOTAL_RESET = 13'd4096;
	localparam logic [COUNT_W-1:0]    COUNT_MAX   = 13'd8191;
	localparam logic [APB_ADDR_W-1:0] ADDR_TOTAL_BLOCKS = 3'd0;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_READ  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		op_t                operation;
		logic [INDEX_W-1:0] block_index;
		logic               bit_value;
	} request_t;

	typedef struct packed {
		logic [INDEX_W-1:0] result_block;
		logic               bit_read;
		status_t            status;
	} response_t;

endpackage

`default_nettype wire

[rtl/block_bitmap_allocator_unit.sv]
// A request is accepted only while the unit is idle; the bitmap word memory is read in the
// accept cycle, and the word is modified and written back in the modify step once the response
// register can take the result. The unit works on one request at a time.
// Reset: arst_n clears the bitmap at once through per-word valid bits (no clearing pass),
// zeroes the in-use count and sets total_blocks to 4096.
`default_nettype none
`include "block_bitmap_allocator_unit_defines.svh"

module block_bitmap_allocator_unit #(
	parameter int NUM_BLOCKS = 4096
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// Request channel
	input  wire                              req_valid,
	output logic                             req_ready,
	input  wire  bba_pkg::request_t          req,
	// Response channel
	output logic                             rsp_valid,
	input  wire                              rsp_ready,
	output bba_pkg::response_t               rsp,
	// Configuration port
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [bba_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire  [bba_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [bba_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	// Only the first 4096 blocks can be addressed by a 12-bit index, so the memory
	// never needs more than 64 words even when the parameter is larger.
	localparam int RAW_WORDS  = (NUM_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
	localparam int WORD_COUNT = (RAW_WORDS < bba_pkg::MAX_WORDS) ? RAW_WORDS
		: bba_pkg::MAX_WORDS;
	localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int LIMIT_CAP  = (NUM_BLOCKS < bba_pkg::INDEX_SPAN) ? NUM_BLOCKS
		: bba_pkg::INDEX_SPAN;

	typedef enum logic {
		ST_IDLE,
		ST_MOD
	} state_t;

	state_t                          state_q;
	logic [bba_pkg::TOTAL_W-1:0]     total_q;
	logic [bba_pkg::COUNT_W-1:0]     count_q;
	logic                            rsp_valid_q;
	bba_pkg::response_t              rsp_q;

	// Request captured at acceptance.
	bba_pkg::op_t                    op_s1;
	logic [bba_pkg::INDEX_W-1:0]     idx_s1;
	logic                            val_s1;
	logic                            range_s1;
	logic                            found_s1;
	logic [ADDR_W-1:0]               waddr_s1;

	// Configuration port. Writes must only arrive while the unit is idle; the unit does not enforce this.
	logic cfg_write;
	assign cfg_write = psel && penable && pwrite && (paddr == bba_pkg::ADDR_TOTAL_BLOCKS);
	assign pready    = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr == bba_pkg::ADDR_TOTAL_BLOCKS) begin
			prdata = bba_pkg::APB_DATA_W'(total_q);
		end
	end

	// The managed total, clipped to the bitmap size and the index range.
	logic [bba_pkg::TOTAL_W-1:0] limit;
	assign limit = (total_q > bba_pkg::TOTAL_W'(LIMIT_CAP)) ? bba_pkg::TOTAL_W'(LIMIT_CAP)
		: total_q;

	// Word search: a word is a candidate when it starts below the limit and its
	// full flag is clear. The lowest candidate holds the lowest clear bit, if any.
	logic [WORD_COUNT-1:0] word_full;
	logic [WORD_COUNT-1:0] word_free;
	logic [ADDR_W-1:0]     first_word;
	logic                  any_free;

	always_comb begin
		for (int w = 0; w < WORD_COUNT; w++) begin
			word_free[w] = !word_full[w] && (limit > bba_pkg::TOTAL_W'(w * bba_pkg::WORD_W));
		end
		first_word = '0;
		for (int w = WORD_COUNT - 1; w >= 0; w--) begin
			if (word_free[w]) begin
				first_word = ADDR_W'(w);
			end
		end
		any_free = |word_free;
	end

	// Request decode in the idle cycle chooses which word to read.
	logic              req_accept;
	logic              req_range;
	logic [ADDR_W-1:0] req_waddr;

	assign req_ready  = (state_q == ST_IDLE);
	assign req_accept = req_valid && req_ready;
	assign req_range  = ({1'b0, req.block_index} >= limit);
	assign req_waddr  = (req.operation == bba_pkg::OP_ALLOC) ? first_word
		: ADDR_W'(req.block_index[bba_pkg::INDEX_W-1:bba_pkg::BIT_SEL_W]);

	always_ff @(posedge clk) begin
		if (req_accept) begin
			op_s1    <= req.operation;
			idx_s1   <= req.block_index;
			val_s1   <= req.bit_value;
			range_s1 <= req_range;
			found_s1 <= any_free;
			waddr_s1 <= req_waddr;
		end
	end

	// Word store.
	logic [bba_pkg::WORD_W-1:0] word_rd;
	logic                       store_wr_en;
	logic [bba_pkg::WORD_W-1:0] store_wr_data;

	bba_word_store #(
		.WORD_COUNT (WORD_COUNT),
		.ADDR_W     (ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (req_accept),
		.rd_addr (req_waddr),
		.rd_data (word_rd),
		.wr_en   (store_wr_en),
		.wr_addr (waddr_s1),
		.wr_data (store_wr_data),
		.full    (word_full)
	);

	// Modify step: find the lowest clear bit of the word just read, or pick the
	// addressed bit, and form the new word, the count change and the response.
	logic [bba_pkg::BIT_SEL_W-1:0] zero_pos;
	logic [bba_pkg::INDEX_W-1:0]   alloc_block;
	logic                          bit_cur;
	logic [bba_pkg::WORD_W-1:0]    alloc_mask;
	logic [bba_pkg::WORD_W-1:0]    idx_mask;
	logic                          wr_need;
	logic                          count_inc;
	logic                          count_dec;
	bba_pkg::response_t            rsp_next;
	logic                          mod_done;

	always_comb begin
		zero_pos = '0;
		for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
			if (!word_rd[b]) begin
				zero_pos = bba_pkg::BIT_SEL_W'(b);
			end
		end
		alloc_block = {bba_pkg::BIT_SEL_W'(waddr_s1), zero_pos};
		alloc_mask  = bba_pkg::WORD_W'(1) << zero_pos;
		idx_mask    = bba_pkg::WORD_W'(1) << idx_s1[bba_pkg::BIT_SEL_W-1:0];
		bit_cur     = word_rd[idx_s1[bba_pkg::BIT_SEL_W-1:0]];

		wr_need       = 1'b0;
		store_wr_data = word_rd;
		count_inc     = 1'b0;
		count_dec     = 1'b0;
		rsp_next      = '{result_block: '0, bit_read: 1'b0, status: bba_pkg::STAT_OK};

		case (op_s1)
			bba_pkg::OP_ALLOC: begin
				if (found_s1 && ({1'b0, alloc_block} < limit)) begin
					wr_need               = 1'b1;
					store_wr_data         = word_rd | alloc_mask;
					count_inc             = 1'b1;
					rsp_next.result_block = alloc_block;
				end else begin
					rsp_next.status = bba_pkg::STAT_FULL;
				end
			end
			bba_pkg::OP_FREE: begin
				if (range_s1) begin
					rsp_next.status = bba_pkg::STAT_RANGE;
				end else begin
					rsp_next.result_block = idx_s1;
					if (bit_cur) begin
						wr_need       = 1'b1;
						store_wr_data = word_rd & ~idx_mask;
						count_dec     = 1'b1;
					end
				end
			end
			bba_pkg::OP_READ: begin
				if (range_s1) begin
					rsp_next.status = bba_pkg::STAT_RANGE;
				end else begin
					rsp_next.bit_read = bit_cur;
				end
			end
			bba_pkg::OP_WRITE: begin
				if (range_s1) begin
					rsp_next.status = bba_pkg::STAT_RANGE;
				end else begin
					wr_need       = 1'b1;
					store_wr_data = val_s1 ? (word_rd | idx_mask) : (word_rd & ~idx_mask);
				end
			end
			default: begin
				rsp_next.status = bba_pkg::STAT_OK;
			end
		endcase
	end

	// The modify step completes once the response register can take the result;
	// until then the read word stays registered and nothing is written.
	assign mod_done    = (state_q == ST_MOD) && (!rsp_valid_q || rsp_ready);
	assign store_wr_en = mod_done && wr_need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= bba_pkg::TOTAL_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '{result_block: '0, bit_read: 1'b0, status: bba_pkg::STAT_OK};
		end else begin
			if (cfg_write) begin
				total_q <= pwdata[bba_pkg::TOTAL_W-1:0];
			end
			// A response leaving in the same cycle as a new one is loaded stays valid.
			if (rsp_valid_q && rsp_ready && !mod_done) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_accept) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
						rsp_q       <= rsp_next;
						if (count_inc && (count_q < bba_pkg::COUNT_MAX)) begin
							count_q <= count_q + 1'b1;
						end else if (count_dec && (count_q != '0)) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Error responses and responses that carry data, for the checks below.
	logic rsp_is_err;
	logic rsp_has_data;
	assign rsp_is_err   = rsp_valid_q && (rsp_q.status != bba_pkg::STAT_OK);
	assign rsp_has_data = (rsp_q.result_block != '0) || rsp_q.bit_read;

	// An accepted request always moves into the modify step.
	`BBA_ASSERT_NEXT(a_accept_to_mod, req_accept, state_q == ST_MOD, "accepted request lost")
	// A finished modify step leaves a response waiting and frees the unit.
	`BBA_ASSERT_NEXT(a_mod_done_rsp, mod_done, rsp_valid_q && req_ready, "response not loaded")
	// Error responses carry no block number and no bit.
	`BBA_ASSERT_NOW(a_err_fields, rsp_is_err, !rsp_has_data, "error response with data")
	// The memory is written only while a modify step completes.
	`BBA_ASSERT_NOW(a_write_in_mod, store_wr_en, !req_ready, "stray bitmap write")

endmodule

`default_nettype wire

[rtl/bba_word_store.sv]
`default_nettype none

// Bitmap word memory with registered read. Per-word valid bits make
// never-written words read as zero; per-word full flags summarize all-ones words.
module bba_word_store #(
	parameter int WORD_COUNT = 64,
	parameter int ADDR_W     = 6
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       rd_en,
	input  wire  [ADDR_W-1:0]         rd_addr,
	output logic [bba_pkg::WORD_W-1:0] rd_data,
	input  wire                       wr_en,
	input  wire  [ADDR_W-1:0]         wr_addr,
	input  wire  [bba_pkg::WORD_W-1:0] wr_data,
	output logic [WORD_COUNT-1:0]     full
);

	logic [bba_pkg::WORD_W-1:0] mem [WORD_COUNT];
	logic [bba_pkg::WORD_W-1:0] rd_raw_q;
	logic                       rd_valid_q;
	logic [WORD_COUNT-1:0]      valid_q;
	logic [WORD_COUNT-1:0]      full_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			full_q     <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
				full_q[wr_addr]  <= &wr_data;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_raw_q : '0;
	assign full    = full_q;

endmodule

`default_nettype wire
